// ===== src/fbpa_pkg.sv =====
`timescale 1ns / 1ps
package fbpa_pkg;

  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned AddrBits  = 32;
  localparam int unsigned QW   = $clog2(MaxBlocks);
  localparam int unsigned IdxW = QW + 1;
  localparam int unsigned SizeW = 16;
  localparam int unsigned CntW  = 11;
  localparam int unsigned RW   = SizeW + IdxW;
  localparam int unsigned CW   = ((RW > AddrBits) ? RW : AddrBits) + 1;
  localparam int unsigned KW   = $clog2(QW + 1);
  localparam int unsigned PAW  = 4;
  localparam int unsigned QDepth = 2;

  localparam logic [IdxW-1:0] NullIdx = IdxW'(MaxBlocks);

  localparam logic [1:0] RegBase  = 2'd0;
  localparam logic [1:0] RegSize  = 2'd1;
  localparam logic [1:0] RegCount = 2'd2;

  localparam logic [31:0] BaseRst  = 32'd4096;
  localparam logic [15:0] SizeRst  = 16'd64;
  localparam logic [10:0] CountRst = 11'd1024;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RESET = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_NOT_OWNED = 3'd3,
    ST_TOO_LARGE = 3'd4
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] address;
  } in_t;

  typedef struct packed {
    logic [31:0] block_address;
    status_e     status;
    logic        owned;
    logic [10:0] free_count;
  } out_t;

  typedef struct packed {
    in_t  item;
    logic addr_null;
  } entry_t;

  typedef struct packed {
    logic [31:0]      base_address;
    logic [SizeW-1:0] block_size;
    logic [CntW-1:0]  block_count;
  } cfg_t;

endpackage

// ===== src/fbpa_ram.sv =====
`timescale 1ns / 1ps
module fbpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== src/fbpa_front.sv =====
`timescale 1ns / 1ps
module fbpa_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fbpa_pkg::in_t    in_data_i,
  output logic             q_valid_o,
  input  logic             q_pop_i,
  output fbpa_pkg::entry_t q_data_o
);
  import fbpa_pkg::*;

  localparam int unsigned PW = (QDepth > 1) ? $clog2(QDepth) : 1;

  entry_t          buf_q [QDepth];
  logic [PW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [PW:0]     cnt_q, cnt_d;
  logic            push;
  entry_t          ent;

  assign in_ready_o = (cnt_q != (PW+1)'(QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = buf_q[rp_q];

  always_comb begin
    ent.item      = in_data_i;
    ent.addr_null = (in_data_i.address == '0);
    wp_d = wp_q;
    rp_d = rp_q;
    if (push) begin
      wp_d = (32'(wp_q) == QDepth - 1) ? '0 : wp_q + 1'b1;
    end
    if (q_pop_i) begin
      rp_d = (32'(rp_q) == QDepth - 1) ? '0 : rp_q + 1'b1;
    end
    cnt_d = cnt_q + (PW+1)'(push) - (PW+1)'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= ent;
    end
  end
endmodule

// ===== src/fbpa_back.sv =====
`timescale 1ns / 1ps
module fbpa_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fbpa_pkg::cfg_t   cfg_i,
  input  logic             q_valid_i,
  output logic             q_pop_o,
  input  fbpa_pkg::entry_t q_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fbpa_pkg::out_t   out_data_o
);
  import fbpa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PREP   = 8'b0000_0010,
    S_EVAL   = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_DIVEND = 8'b0001_0000,
    S_SWEEP  = 8'b0010_0000,
    S_RDLINK = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e           st_q, st_d;
  entry_t           ent_q, ent_d;
  logic [IdxW-1:0]  head_q, head_d, free_q, free_d, n_q, n_d, eff_q, eff_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic             ready_q, ready_d;
  logic [RW-1:0]    region_q, region_d, prod_q, prod_d, rem_q, rem_d;
  logic [QW-1:0]    quo_q, quo_d;
  logic [KW-1:0]    k_q, k_d;
  out_t             res_q, res_d, obuf_q, obuf_d;
  logic             ovalid_q, ovalid_d;

  logic             we;
  logic [QW-1:0]    waddr, raddr;
  logic [IdxW-1:0]  wdata, rdata;

  logic [IdxW-1:0]  eff;
  logic [CW-1:0]    sum, off_w, hi;
  logic [31:0]      off;
  logic [RW-1:0]    trial;
  logic             pre_fail, too_large;

  fbpa_ram #(.Width(IdxW), .Depth(MaxBlocks)) u_link (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_valid_o = ovalid_q;
  assign out_data_o  = obuf_q;

  always_comb begin
    eff   = (32'(cfg_i.block_count) > MaxBlocks) ? IdxW'(MaxBlocks) : IdxW'(cfg_i.block_count);
    sum   = CW'(cfg_i.base_address) + CW'(region_q);
    hi    = sum >> AddrBits;
    too_large = (region_q != '0) &&
                ((hi > CW'(1)) || ((hi == CW'(1)) && (sum[AddrBits-1:0] != '0)));
    off   = ent_q.item.address - cfg_i.base_address;
    off_w = CW'(off);
    pre_fail = ent_q.addr_null || (cfg_i.block_size == '0) ||
               (ent_q.item.address < cfg_i.base_address) || (off_w >= CW'(region_q));
    trial = RW'(cfg_i.block_size) << k_q;

    st_d = st_q; ent_d = ent_q; head_d = head_q; free_d = free_q; n_d = n_q;
    eff_d = eff_q; cnt_d = cnt_q; ready_d = ready_q; region_d = region_q;
    prod_d = prod_q; rem_d = rem_q; quo_d = quo_q; k_d = k_q; res_d = res_q;
    obuf_d = obuf_q; ovalid_d = ovalid_q;
    q_pop_o = 1'b0;
    we = 1'b0; waddr = cnt_q[QW-1:0]; wdata = '0; raddr = head_q[QW-1:0];

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (st_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          ent_d   = q_data_i;
          st_d    = S_PREP;
        end
      end
      S_PREP: begin
        n_d      = (cfg_i.block_size == '0) ? '0 : eff;
        eff_d    = eff;
        region_d = RW'(cfg_i.block_size) * RW'(eff);
        prod_d   = RW'(cfg_i.block_size) * RW'(head_q[QW-1:0]);
        res_d    = '0;
        res_d.status = ST_OK;
        st_d     = S_EVAL;
      end
      S_EVAL: begin
        st_d = S_DONE;
        if (ent_q.item.op == OP_RESET) begin
          if (too_large) begin
            res_d.status = ST_TOO_LARGE;
          end else if (n_q == '0) begin
            head_d = NullIdx; free_d = '0; ready_d = 1'b1;
          end else begin
            cnt_d = '0;
            st_d  = S_SWEEP;
          end
        end else if (!ready_q) begin
          res_d.status = ST_NOT_READY;
        end else if (ent_q.item.op == OP_ALLOC) begin
          if (head_q >= NullIdx) begin
            res_d.status = ST_EXHAUSTED;
          end else begin
            res_d.block_address = cfg_i.base_address + 32'(prod_q);
            st_d = S_RDLINK;
          end
        end else if (ent_q.item.op == OP_FREE) begin
          if (!ent_q.addr_null) begin
            if (pre_fail) begin
              res_d.status = ST_NOT_OWNED;
            end else begin
              rem_d = RW'(off); quo_d = '0; k_d = KW'(QW - 1); st_d = S_DIV;
            end
          end
        end else begin
          if (!pre_fail) begin
            rem_d = RW'(off); quo_d = '0; k_d = KW'(QW - 1); st_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (rem_q >= trial) begin
          rem_d = rem_q - trial;
          quo_d = quo_q | (QW'(1) << k_q);
        end
        k_d = k_q - 1'b1;
        if (k_q == '0) begin
          st_d = S_DIVEND;
        end
      end
      S_DIVEND: begin
        st_d = S_DONE;
        if (ent_q.item.op == OP_FREE) begin
          if (rem_q != '0) begin
            res_d.status = ST_NOT_OWNED;
          end else begin
            we = 1'b1; waddr = quo_q; wdata = head_q;
            head_d = IdxW'(quo_q);
            if (free_q < eff_q) begin
              free_d = free_q + 1'b1;
            end
          end
        end else begin
          res_d.owned = (rem_q == '0);
        end
      end
      S_SWEEP: begin
        we    = 1'b1;
        wdata = (cnt_q + 1'b1 < n_q) ? cnt_q + 1'b1 : NullIdx;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q + 1'b1 >= n_q) begin
          head_d = '0; free_d = n_q; ready_d = 1'b1; st_d = S_DONE;
        end
      end
      S_RDLINK: begin
        head_d = (rdata > NullIdx) ? NullIdx : rdata;
        if (free_q != '0) begin
          free_d = free_q - 1'b1;
        end
        st_d = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          obuf_d = res_q;
          obuf_d.free_count = CntW'(free_q);
          ovalid_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      head_q   <= NullIdx;
      free_q   <= '0;
      ready_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      head_q   <= head_d;
      free_q   <= free_d;
      ready_q  <= ready_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q    <= ent_d;
    n_q      <= n_d;
    eff_q    <= eff_d;
    cnt_q    <= cnt_d;
    region_q <= region_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    k_q      <= k_d;
    res_q    <= res_d;
    obuf_q   <= obuf_d;
  end
endmodule

// ===== src/fixed_block_pool_allocator_unit.sv =====
`timescale 1ns / 1ps
// channel  handshake               payload
// in       in_valid_i/in_ready_o   in_data_i   (op, address)
// out      out_valid_o/out_ready_i out_data_o  (block_address, status, owned, free_count)
// cfg      psel/penable/pwrite     paddr, pwdata, prdata
// Allocate runs a multiply stage, then a registered link memory read.
// Free and query run a one-bit-a-cycle remainder loop.
// Reset and relink does one link memory write per block.
// A two-beat queue takes input while the back end works or the output waits.
// The link memory needs no clearing after reset.
module fixed_block_pool_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  fbpa_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output fbpa_pkg::out_t              out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fbpa_pkg::PAW-1:0]    paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fbpa_pkg::*;

  cfg_t   cfg_q;
  entry_t qd;
  logic   qv, qpop;
  logic   wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      RegBase:  prdata = cfg_q.base_address;
      RegSize:  prdata = 32'(cfg_q.block_size);
      RegCount: prdata = 32'(cfg_q.block_count);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_address <= BaseRst;
      cfg_q.block_size   <= SizeRst;
      cfg_q.block_count  <= CountRst;
    end else if (wr) begin
      unique case (paddr[3:2])
        RegBase:  cfg_q.base_address <= pwdata;
        RegSize:  cfg_q.block_size   <= pwdata[SizeW-1:0];
        RegCount: cfg_q.block_count  <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  fbpa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (qv),
    .q_pop_i    (qpop),
    .q_data_o   (qd)
  );

  fbpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (qv),
    .q_pop_o     (qpop),
    .q_data_i    (qd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );
endmodule

// ===== bench/fbpa_checker.sv =====
`timescale 1ns / 1ps
module fbpa_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  fbpa_pkg::in_t            in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  fbpa_pkg::out_t           out_data_i,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic                     pready_i,
  input  logic [fbpa_pkg::PAW-1:0] paddr_i,
  input  logic [31:0]              pwdata_i,
  output int                       fails_o,
  output int                       pending_o
);
  import fbpa_pkg::*;

  logic [31:0]      base_q  = BaseRst;
  logic [15:0]      size_q  = SizeRst;
  logic [10:0]      count_q = CountRst;
  logic [10:0]      links [MaxBlocks];
  logic [10:0]      head_q  = NullIdx;
  logic             pool_rdy = 1'b0;
  logic [10:0]      free_cnt = '0;
  out_t             results_due[$];
  int               fails = 0;

  initial begin
    fails_o   = 0;
    pending_o = 0;
  end

  function automatic logic [10:0] usable_blocks();
    return (count_q > 11'(MaxBlocks)) ? 11'(MaxBlocks) : count_q;
  endfunction

  function automatic logic block_owned(input logic [31:0] a, output logic [10:0] idx);
    logic [63:0] region;
    logic [63:0] off;
    region = 64'(size_q) * 64'(usable_blocks());
    idx = '0;
    if (a == 0 || size_q == 0 || a < base_q) return 1'b0;
    off = 64'(a) - 64'(base_q);
    if (off >= region || (off % size_q) != 0) return 1'b0;
    idx = 11'(off / size_q);
    return 1'b1;
  endfunction

  function automatic out_t pool_op(input in_t beat);
    out_t        r;
    logic [10:0] n;
    logic [10:0] idx;
    logic [63:0] region;
    logic [63:0] a;
    r = '0;
    r.status = ST_OK;
    if (beat.op == OP_RESET) begin
      n = (size_q == 0) ? 11'd0 : usable_blocks();
      region = 64'(size_q) * 64'(n);
      if (region != 0 && 64'(base_q) + region - 1 > 64'hFFFF_FFFF) begin
        r.status = ST_TOO_LARGE;
      end else begin
        for (int i = 0; i < n; i++) links[i] = (i + 1 < n) ? 11'(i + 1) : NullIdx;
        head_q   = (n > 0) ? 11'd0 : NullIdx;
        free_cnt = n;
        pool_rdy = 1'b1;
      end
    end else if (!pool_rdy) begin
      r.status = ST_NOT_READY;
    end else if (beat.op == OP_ALLOC) begin
      if (head_q >= 11'(MaxBlocks)) begin
        r.status = ST_EXHAUSTED;
      end else begin
        a = 64'(base_q) + 64'(head_q) * 64'(size_q);
        r.block_address = a[31:0];
        head_q = links[head_q];
        if (head_q > NullIdx) head_q = NullIdx;
        if (free_cnt > 0) free_cnt--;
      end
    end else if (beat.op == OP_FREE) begin
      if (beat.address != 0) begin
        if (block_owned(beat.address, idx) && idx < 11'(MaxBlocks)) begin
          links[idx] = head_q;
          head_q = idx;
          if (free_cnt < usable_blocks()) free_cnt++;
        end else begin
          r.status = ST_NOT_OWNED;
        end
      end
    end else begin
      r.owned = block_owned(beat.address, idx);
    end
    r.free_count = free_cnt;
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          RegBase:  base_q  = pwdata_i;
          RegSize:  size_q  = pwdata_i[15:0];
          RegCount: count_q = pwdata_i[10:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) results_due.push_back(pool_op(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result beat %p", out_data_i);
        end else begin
          want = results_due.pop_front();
          if (want.block_address !== out_data_i.block_address ||
              want.status !== out_data_i.status || want.owned !== out_data_i.owned ||
              want.free_count !== out_data_i.free_count) begin
            fails++;
            if (fails <= 10)
              $display({"mismatch: expected addr %h st %0d own %0d free %0d,",
                        " got addr %h st %0d own %0d free %0d"},
                       want.block_address, want.status, want.owned, want.free_count,
                       out_data_i.block_address, out_data_i.status, out_data_i.owned,
                       out_data_i.free_count);
          end
        end
      end
      fails_o   <= fails;
      pending_o <= results_due.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import fbpa_pkg::*;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  in_t            in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  out_t           out_data;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;
  int             fails;
  int             pending;
  logic           calm = 1'b0;
  logic           stall_go = 1'b0;
  int             cycles = 0;

  logic [31:0]    cur_base = BaseRst;
  logic [15:0]    cur_size = SizeRst;
  logic [10:0]    cur_count = CountRst;

  always #5 clk = ~clk;

  fixed_block_pool_allocator_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  fbpa_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata), .fails_o(fails), .pending_o(pending)
  );

  // result side: random back-pressure plus one long hold-off
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (stall_go && !held) begin
        held = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 38);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("FAIL fixed_block_pool_allocator_unit");
      $finish;
    end
  end

  task automatic send(input op_e op, input logic [31:0] a);
    if (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: op, address: a};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_pool(input logic [31:0] b, input logic [15:0] s, input logic [10:0] c);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);
    reg_write(RegBase, b);
    reg_write(RegSize, {16'h0, s});
    reg_write(RegCount, {21'h0, c});
    cur_base  = b;
    cur_size  = s;
    cur_count = c;
  endtask

  function automatic logic [31:0] pick_addr();
    int          k;
    logic [10:0] n;
    n = (cur_count > 11'd1024) ? 11'd1024 : cur_count;
    k = $urandom_range(99);
    if (k < 60) return cur_base + 32'($urandom_range(n)) * cur_size;
    if (k < 75) return cur_base + 32'($urandom_range(n)) * cur_size + 32'($urandom_range(1, 3));
    if (k < 90) return $urandom;
    return 32'h0;
  endfunction

  task automatic random_ops(input int count);
    int k;
    send(OP_RESET, $urandom);
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 38) send(OP_ALLOC, $urandom);
      else if (k < 75) send(OP_FREE, pick_addr());
      else if (k < 97) send(OP_QUERY, pick_addr());
      else send(OP_RESET, $urandom);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(OP_ALLOC, 32'h0);
    send(OP_FREE, 32'h0);
    send(OP_FREE, 32'h1000);
    send(OP_QUERY, 32'h1000);
    send(OP_RESET, 32'h0);
    send(OP_ALLOC, 32'hFFFF_FFFF);
    send(OP_ALLOC, 32'h0);
    send(OP_FREE, 32'h0);
    send(OP_FREE, 32'h1040);
    send(OP_FREE, 32'h1040);
    send(OP_FREE, 32'h0FFF);
    send(OP_FREE, 32'h1041);
    send(OP_FREE, 32'hFFFF_FFFF);
    send(OP_FREE, 32'h1000 + 32'd1024 * 32'd64);
    send(OP_QUERY, 32'h1000);
    send(OP_QUERY, 32'h0);
    send(OP_QUERY, 32'h1000 + 32'd1023 * 32'd64);
    send(OP_QUERY, 32'h1000 + 32'd1024 * 32'd64);

    set_pool(32'h1, 16'd4, 11'd2);
    send(OP_RESET, 32'h0);
    send(OP_ALLOC, 32'h0);
    send(OP_ALLOC, 32'h0);
    send(OP_ALLOC, 32'h0);
    set_pool(32'hFFFF_FFFF, 16'hFFFF, 11'd1);
    send(OP_RESET, 32'h0);
    send(OP_QUERY, 32'hFFFF_FFFF);

    set_pool(32'hFFFF_0000, 16'hFFFF, 11'd1);   random_ops(120);
    set_pool(32'h1000, 16'd12, 11'h7FF);        random_ops(100);
    set_pool(32'h20, 16'd0, 11'd5);             random_ops(40);
    set_pool(32'h40, 16'd8, 11'd0);             random_ops(40);
    set_pool(32'h8000_0000, 16'h100, 11'd7);
    calm = 1'b1;
    random_ops(200);
    calm = 1'b0;
    for (int p = 0; p < 11; p++) begin
      if (p == 3) stall_go = 1'b1;
      if (p == 5) set_pool($urandom, 16'(4 * $urandom_range(1, 16383)), 11'($urandom_range(1, 2047)));
      else set_pool($urandom_range(1, 32'hFFFF), 16'(4 * $urandom_range(1, 64)),
                    11'($urandom_range(1, 16)));
      random_ops(120);
    end
    set_pool(BaseRst, SizeRst, CountRst);
    random_ops(30);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) $display("PASS fixed_block_pool_allocator_unit");
    else $display("FAIL fixed_block_pool_allocator_unit");
    $finish;
  end

endmodule

// ===== fixed_block_pool_allocator_unit.f =====
src/fbpa_pkg.sv
src/fbpa_ram.sv
src/fbpa_front.sv
src/fbpa_back.sv
src/fixed_block_pool_allocator_unit.sv
bench/fbpa_checker.sv
bench/tb_top.sv
